>>> design/pst_pkg.sv
`default_nettype none

package pst_pkg;

    localparam int MAX_POSITIONS_DEF = 1024;

    localparam int INDEX_W = 11;
    localparam int WALK_W  = INDEX_W + 1;
    localparam int SUM_W   = 64;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register word index, taken from paddr above the byte offset
    localparam logic [PADDR_W-3:0] REG_SIZE_IN_USE = 1'b0;
    localparam logic [INDEX_W-1:0] SIZE_RESET      = 11'd1024;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic clr;
        logic load_add;
        logic load_query;
        logic load_lo;
        logic step;
        logic sub;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic active;
        logic pend;
    } dp_stat_t;

    function automatic logic [WALK_W-1:0] low_bit(input logic [WALK_W-1:0] x);
        low_bit = x & (~x + 1'b1);
    endfunction

endpackage

`default_nettype wire

>>> design/pst_datapath.sv
`default_nettype none

module pst_datapath #(
    parameter int MAX_POSITIONS = pst_pkg::MAX_POSITIONS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire pst_pkg::dp_cmd_t            cmd,
    output pst_pkg::dp_stat_t                stat,
    input  wire [pst_pkg::INDEX_W-1:0]       n,
    input  wire [pst_pkg::INDEX_W-1:0]       first_index,
    input  wire [pst_pkg::INDEX_W-1:0]       last_index,
    input  wire signed [pst_pkg::SUM_W-1:0]  add_value,
    output logic signed [pst_pkg::SUM_W-1:0] range_sum
);

    localparam int AW    = (MAX_POSITIONS < 2) ? 1 : $clog2(MAX_POSITIONS + 1);
    localparam int DEPTH = MAX_POSITIONS + 1;

    logic [pst_pkg::SUM_W-1:0] mem [0:DEPTH-1];

    logic [AW-1:0]                  clr_cnt_reg, clr_cnt_next;
    logic [pst_pkg::WALK_W-1:0]     x_reg, x_next;
    logic [pst_pkg::SUM_W-1:0]      v_reg;
    logic [pst_pkg::SUM_W-1:0]      acc_reg, acc_next;
    logic [pst_pkg::INDEX_W-1:0]    below_reg;
    logic                           mode_add_reg;
    logic                           pend_valid_reg, pend_valid_next;
    logic                           pend_sub_reg;
    logic [AW-1:0]                  pend_addr_reg;
    logic [pst_pkg::SUM_W-1:0]      rdata_reg;
    logic [pst_pkg::SUM_W-1:0]      sum_out_reg;

    logic [pst_pkg::WALK_W-1:0]     lb;
    logic                           active;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [pst_pkg::INDEX_W-1:0]    last_clamp;
    logic [pst_pkg::INDEX_W-1:0]    first_m1;
    logic [pst_pkg::INDEX_W-1:0]    below_clamp;

    assign lb      = pst_pkg::low_bit(x_reg);
    assign active  = mode_add_reg ? ((x_reg != '0) && (x_reg <= {1'b0, n}))
                                  : (x_reg != '0);
    assign rd_en   = cmd.step && active;
    // x never exceeds the memory depth while a read is issued
    assign rd_addr = AW'(x_reg);

    assign last_clamp  = (last_index > n) ? n : last_index;
    assign first_m1    = (first_index == '0) ? '0 : first_index - 1'b1;
    assign below_clamp = (first_m1 > n) ? n : first_m1;

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clr) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_comb begin
        x_next = x_reg;
        if (cmd.load_add) begin
            x_next = {1'b0, first_index};
        end else if (cmd.load_query) begin
            x_next = {1'b0, last_clamp};
        end else if (cmd.load_lo) begin
            x_next = {1'b0, below_reg};
        end else if (rd_en) begin
            x_next = mode_add_reg ? (x_reg + lb) : (x_reg - lb);
        end
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.load_query) begin
            acc_next = '0;
        end else if (pend_valid_reg && !mode_add_reg) begin
            acc_next = pend_sub_reg ? (acc_reg - rdata_reg) : (acc_reg + rdata_reg);
        end
    end

    assign pend_valid_next = rd_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        acc_reg       <= acc_next;
        pend_sub_reg  <= cmd.sub;
        pend_addr_reg <= rd_addr;
        if (cmd.load_add) begin
            v_reg        <= add_value;
            mode_add_reg <= 1'b1;
        end else if (cmd.load_query) begin
            below_reg    <= below_clamp;
            mode_add_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            sum_out_reg <= acc_reg;
        end
    end

    // one write port (clear pass or read-modify-write), one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clr) begin
            mem[clr_cnt_reg] <= '0;
        end else if (pend_valid_reg && mode_add_reg) begin
            mem[pend_addr_reg] <= rdata_reg + v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign stat.clr_last = (clr_cnt_reg == AW'(MAX_POSITIONS));
    assign stat.active   = active;
    assign stat.pend     = pend_valid_reg;
    assign range_sum     = sum_out_reg;

endmodule

`default_nettype wire

>>> design/pst_ctrl.sv
`default_nettype none

module pst_ctrl (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire                    s_operation,
    output logic                   m_valid,
    input  wire                    m_ready,
    output pst_pkg::dp_cmd_t       cmd,
    input  wire pst_pkg::dp_stat_t stat
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_QHI   = 3'd3;
    localparam logic [2:0] ST_QLO   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == pst_pkg::OP_ADD) begin
                        cmd.load_add = 1'b1;
                        state_next   = ST_ADD;
                    end else begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_QHI;
                    end
                end
            end
            ST_ADD: begin
                cmd.step = 1'b1;
                if (!stat.active && !stat.pend) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QHI: begin
                cmd.step = 1'b1;
                if (!stat.active) begin
                    cmd.load_lo = 1'b1;
                    state_next  = ST_QLO;
                end
            end
            ST_QLO: begin
                cmd.step = 1'b1;
                cmd.sub  = 1'b1;
                if (!stat.active && !stat.pend) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> design/prefix_sum_tree_update_query_unit.sv
// channel   direction  signals                                          accepted when
// s_        in         s_operation s_first_index s_last_index s_add_value s_valid & s_ready
// m_        out        m_range_sum                                      m_valid & m_ready
// apb       in         psel penable pwrite paddr pwdata prdata pready   psel & penable & pwrite
//
// after reset a clearing pass writes zero to all MAX_POSITIONS+1 entries, one per cycle;
// s_ready stays low during the pass, configuration writes still go in
// an add walks upward from its position through the nodes it covers, reading and
// rewriting each one, and walks no node when its position is out of range;
// a query makes two downward walks, one from the last index and one from the index
// below the first, through the single read port of the sum memory
// a finished sum sits in the output register; the next request is taken while it waits
`default_nettype none

module prefix_sum_tree_update_query_unit #(
    parameter int MAX_POSITIONS = pst_pkg::MAX_POSITIONS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_operation,
    input  wire [pst_pkg::INDEX_W-1:0]         s_first_index,
    input  wire [pst_pkg::INDEX_W-1:0]         s_last_index,
    input  wire signed [pst_pkg::SUM_W-1:0]    s_add_value,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic signed [pst_pkg::SUM_W-1:0]  m_range_sum,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [pst_pkg::PADDR_W-1:0]         paddr,
    input  wire [pst_pkg::PDATA_W-1:0]         pwdata,
    output logic [pst_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [pst_pkg::INDEX_W-1:0] size_reg, size_next;
    logic [pst_pkg::INDEX_W-1:0] n;
    logic                        reg_hit;
    pst_pkg::dp_cmd_t            cmd;
    pst_pkg::dp_stat_t           stat;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[pst_pkg::PADDR_W-1:2] == pst_pkg::REG_SIZE_IN_USE);

    always_comb begin
        size_next = size_reg;
        if (psel && penable && pwrite && reg_hit) begin
            size_next = pwdata[pst_pkg::INDEX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= pst_pkg::SIZE_RESET;
        end else begin
            size_reg <= size_next;
        end
    end

    assign prdata = reg_hit ? {{(pst_pkg::PDATA_W-pst_pkg::INDEX_W){1'b0}}, size_reg} : '0;

    // positions in use, limited to MAX_POSITIONS
    assign n = (32'(size_reg) > MAX_POSITIONS) ? pst_pkg::INDEX_W'(MAX_POSITIONS) : size_reg;

    pst_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .stat        (stat)
    );

    pst_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .n           (n),
        .first_index (s_first_index),
        .last_index  (s_last_index),
        .add_value   (s_add_value),
        .range_sum   (m_range_sum)
    );

endmodule

`default_nettype wire

>>> design/pst_checker.sv
`default_nettype none

module pst_checker (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_valid,
    input wire                             s_ready,
    input wire                             s_operation,
    input wire                             m_valid,
    input wire                             m_ready,
    input wire [pst_pkg::SUM_W-1:0]        m_range_sum,
    input wire                             pready
);

    // no result is pending right after reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // an accepted request occupies the block, so s_ready drops once it is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("s_ready high right after a request");

    // an add request never makes a result appear
    a_add_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_operation == pst_pkg::OP_ADD) && !m_valid |=> !m_valid)
        else $error("result after add request");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_range_sum))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind prefix_sum_tree_update_query_unit pst_checker u_pst_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_operation (s_operation),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_range_sum (m_range_sum),
    .pready      (pready)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [pst_pkg::SUM_W-1:0] SUM_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [pst_pkg::SUM_W-1:0] SUM_MIN = 64'h8000_0000_0000_0000;
    localparam logic [pst_pkg::SUM_W-1:0] SUM_ONES = 64'hffff_ffff_ffff_ffff;
    localparam int PHASES = 9;
    localparam int PHASE_REQUESTS = 160;
    localparam int SETTLE_CYCLES = 64;

    typedef struct packed {
        logic                        op;
        logic [pst_pkg::INDEX_W-1:0] first_pos;
        logic [pst_pkg::INDEX_W-1:0] last_pos;
        logic [pst_pkg::SUM_W-1:0]   amount;
        logic                        typed;
        logic [pst_pkg::SUM_W-1:0]   typed_sum;
    } step_row_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    wire                          s_ready;
    logic                         s_operation = pst_pkg::OP_ADD;
    logic [pst_pkg::INDEX_W-1:0]  s_first_index = '0;
    logic [pst_pkg::INDEX_W-1:0]  s_last_index = '0;
    logic [pst_pkg::SUM_W-1:0]    s_add_value = '0;
    wire                          m_valid;
    logic                         m_ready = 1'b0;
    wire  [pst_pkg::SUM_W-1:0]    m_range_sum;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [pst_pkg::PADDR_W-1:0]  paddr = '0;
    logic [pst_pkg::PDATA_W-1:0]  pwdata = '0;
    wire  [pst_pkg::PDATA_W-1:0]  prdata;
    wire                          pready;

    // predictor state
    logic [pst_pkg::SUM_W-1:0]    node_sums [0:pst_pkg::MAX_POSITIONS_DEF];
    logic [pst_pkg::INDEX_W-1:0]  size_reg = pst_pkg::SIZE_RESET;
    logic [pst_pkg::SUM_W-1:0]    expected_sums [$];
    logic [pst_pkg::SUM_W-1:0]    oldest_sum;
    int                           mismatches = 0;
    int                           send_idle_pct = 8;
    int                           recv_idle_pct = 73;

    // store is all zero after reset, so the early sums can be read off directly
    step_row_t directed_steps [24] = '{
        '{pst_pkg::OP_QUERY, 11'd1,    11'd1024, 64'd0,    1'b1, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd0,    11'd0,    64'd0,    1'b1, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd2047, 11'd2047, 64'd0,    1'b1, 64'd0},
        '{pst_pkg::OP_ADD,   11'd0,    11'd0,    64'd5,    1'b0, 64'd0},
        '{pst_pkg::OP_ADD,   11'd1025, 11'd3,    64'd7,    1'b0, 64'd0},
        '{pst_pkg::OP_ADD,   11'd2047, 11'd2047, SUM_ONES, 1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd0,    11'd2047, 64'd0,    1'b1, 64'd0},
        '{pst_pkg::OP_ADD,   11'd1,    11'd0,    SUM_MAX,  1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd1,    11'd1,    64'd0,    1'b1, SUM_MAX},
        '{pst_pkg::OP_ADD,   11'd1024, 11'd0,    SUM_MIN,  1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd1024, 11'd1024, 64'd0,    1'b1, SUM_MIN},
        '{pst_pkg::OP_QUERY, 11'd1,    11'd1024, 64'd0,    1'b1, SUM_ONES},
        '{pst_pkg::OP_ADD,   11'd1,    11'd0,    64'd1,    1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd1,    11'd1,    64'd0,    1'b1, SUM_MIN},
        '{pst_pkg::OP_ADD,   11'd512,  11'd0,    SUM_ONES, 1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd600,  11'd3,    64'd0,    1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd0,    11'd512,  64'd0,    1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd513,  11'd2047, SUM_ONES, 1'b0, 64'd0},
        '{pst_pkg::OP_ADD,   11'd1023, 11'd2047, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd1023, 11'd1023, 64'd0,    1'b1, 64'h5555_5555_5555_5555},
        '{pst_pkg::OP_QUERY, 11'd2,    11'd1023, 64'd0,    1'b0, 64'd0},
        '{pst_pkg::OP_ADD,   11'd1024, 11'd0,    64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd1000, 11'd1024, 64'd0,    1'b0, 64'd0},
        '{pst_pkg::OP_QUERY, 11'd1024, 11'd1,    64'd0,    1'b0, 64'd0}
    };

    prefix_sum_tree_update_query_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_first_index (s_first_index),
        .s_last_index  (s_last_index),
        .s_add_value   (s_add_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_range_sum   (m_range_sum),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic flag_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    function automatic int unsigned covered_span();
        return (size_reg > pst_pkg::MAX_POSITIONS_DEF) ? pst_pkg::MAX_POSITIONS_DEF
                                                       : int'(size_reg);
    endfunction

    function automatic logic [pst_pkg::SUM_W-1:0] prefix_total(input int unsigned pos);
        int unsigned n;
        int unsigned x;
        logic [pst_pkg::SUM_W-1:0] acc;
        n = covered_span();
        x = (pos > n) ? n : pos;
        acc = '0;
        while (x > 0) begin
            acc += node_sums[x];
            x -= x & (~x + 1);
        end
        return acc;
    endfunction

    function automatic void point_update(input int unsigned pos,
                                         input logic [pst_pkg::SUM_W-1:0] amount);
        int unsigned n;
        int unsigned x;
        n = covered_span();
        if (pos == 0 || pos > n) begin
            return;
        end
        x = pos;
        while (x <= n) begin
            node_sums[x] += amount;
            x += x & (~x + 1);
        end
    endfunction

    function automatic void predict_request(input step_row_t req);
        int unsigned below;
        logic [pst_pkg::SUM_W-1:0] sum;
        if (req.op == pst_pkg::OP_ADD) begin
            point_update(req.first_pos, req.amount);
        end else begin
            below = (req.first_pos == 0) ? 0 : req.first_pos - 1;
            sum = prefix_total(req.last_pos) - prefix_total(below);
            expected_sums.push_back(req.typed ? req.typed_sum : sum);
        end
    endfunction

    // valid stays high into the next request unless a gap is drawn here
    task automatic send_request(input step_row_t req);
        s_valid <= 1'b1;
        s_operation <= req.op;
        s_first_index <= req.first_pos;
        s_last_index <= req.last_pos;
        s_add_value <= req.amount;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_request(req);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
    endtask

    task automatic send_random();
        step_row_t req;
        int unsigned n;
        n = covered_span();
        req.op = logic'($urandom_range(0, 1));
        req.typed = 1'b0;
        req.typed_sum = '0;
        if (n > 0 && $urandom_range(0, 99) < 80) begin
            req.first_pos = pst_pkg::INDEX_W'($urandom_range(1, n));
            req.last_pos = pst_pkg::INDEX_W'($urandom_range(req.first_pos, n));
            if ($urandom_range(0, 9) == 0) begin
                req.first_pos = '0;
            end
        end else begin
            req.first_pos = pst_pkg::INDEX_W'($urandom_range(0, 2047));
            req.last_pos = pst_pkg::INDEX_W'($urandom_range(0, 2047));
        end
        case ($urandom_range(0, 9))
            0: req.amount = SUM_MAX;
            1: req.amount = SUM_MIN;
            2, 3: req.amount = 64'(int'($urandom_range(0, 15)) - 8);
            default: req.amount = {$urandom, $urandom};
        endcase
        send_request(req);
    endtask

    task automatic write_size(input logic [pst_pkg::INDEX_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {pst_pkg::REG_SIZE_IN_USE, 2'b00};
        pwdata <= {21'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        size_reg = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // hold off requests until every sum is back, then let any add finish its walk
    task automatic wait_idle();
        int unsigned waited;
        s_valid <= 1'b0;
        waited = 0;
        while (expected_sums.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_sums.size() != 0) begin
            flag_mismatch($sformatf("%0d expected sums never arrived", expected_sums.size()));
            expected_sums.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_sums.size() == 0) begin
                flag_mismatch($sformatf("unexpected range_sum %h", m_range_sum));
            end else begin
                oldest_sum = expected_sums.pop_front();
                if (m_range_sum !== oldest_sum) begin
                    flag_mismatch($sformatf("range_sum got %h expected %h",
                                            m_range_sum, oldest_sum));
                end
            end
        end
    end

    initial begin
        logic [pst_pkg::INDEX_W-1:0] phase_sizes [PHASES];
        phase_sizes = '{11'd16, 11'd1, 11'd0, 11'd2047, 11'd1024, 11'd5, 11'd0,
                        11'd1024, 11'd300};
        phase_sizes[6] = pst_pkg::INDEX_W'($urandom_range(2, 1023));
        for (int i = 0; i <= pst_pkg::MAX_POSITIONS_DEF; i++) begin
            node_sums[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i]) begin
            send_request(directed_steps[i]);
        end
        wait_idle();

        for (int phase = 0; phase < PHASES; phase++) begin
            send_idle_pct = (phase < 3) ? 8 : (phase < 6) ? 73 : 0;
            recv_idle_pct = (phase < 3) ? 73 : (phase < 6) ? 8 : 0;
            write_size(phase_sizes[phase]);
            repeat (PHASE_REQUESTS) begin
                send_random();
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
design/pst_pkg.sv
design/pst_datapath.sv
design/pst_ctrl.sv
design/prefix_sum_tree_update_query_unit.sv
design/pst_checker.sv
verif/tb.sv
